[design/two_voice_note_sequencer_assert.svh]
// Assertion macros for the two-voice note sequencer.
// Used by the top level; expects clk and arst_n in scope.
`ifndef TWO_VOICE_NOTE_SEQUENCER_ASSERT_SVH
`define TWO_VOICE_NOTE_SEQUENCER_ASSERT_SVH

// Condition a implies condition c in the same cycle.
`define TVNS_ASSERT_NOW(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("tvns: same-cycle check failed");

// Condition a implies condition c in the next cycle.
`define TVNS_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("tvns: next-cycle check failed");

`endif

[design/tvns_pkg.sv]
// Types, command and register codes, and the melody ROM of the
// two-voice note sequencer. No dependencies.
package tvns_pkg;

	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_BIASED = 2'd1;
	localparam logic [1:0] CMD_START  = 2'd2;
	localparam logic [1:0] CMD_STOP   = 2'd3;

	localparam logic [1:0] REG_MIN_DUTY   = 2'd0;
	localparam logic [1:0] REG_MAX_DUTY   = 2'd1;
	localparam logic [1:0] REG_PLAIN_DUTY = 2'd2;

	localparam logic [15:0] MIN_DUTY_RST   = 16'd3277;
	localparam logic [15:0] MAX_DUTY_RST   = 16'd62259;
	localparam logic [15:0] PLAIN_DUTY_RST = 16'd32768;

	localparam int TABLE_MELODIES = 8;

	typedef struct packed {
		logic [1:0]         command;
		logic [31:0]        now_ms;
		logic [2:0]         melody_select;
		logic signed [15:0] left_trim;
		logic signed [15:0] right_trim;
	} item_t;

	typedef struct packed {
		logic        playing;
		logic        note_valid;
		logic [11:0] left_freq;
		logic [11:0] right_freq;
		logic [15:0] left_duty;
		logic [15:0] right_duty;
		logic        audio_begin;
		logic        audio_end;
	} result_t;

	typedef struct packed {
		logic        active;
		logic [4:0]  ptr;
		logic [4:0]  lim;
		logic [31:0] end_time;
	} state_t;

	typedef struct packed {
		logic [15:0] min_duty;
		logic [15:0] max_duty;
		logic [15:0] plain_duty;
	} cfg_t;

	typedef struct packed {
		logic [11:0] lf;
		logic [8:0]  ld;
		logic [11:0] rf;
		logic [8:0]  rd;
	} note_t;

	function automatic note_t mk(input int lf, input int ld, input int rf, input int rd);
		mk = '{lf: 12'(lf), ld: 9'(ld), rf: 12'(rf), rd: 9'(rd)};
	endfunction

	// Note ROM; steps past the last melody read as a silent pair.
	function automatic note_t note_lookup(input logic [4:0] idx);
		unique case (idx)
			5'd0:    note_lookup = mk(349, 99, 311, 99);
			5'd1:    note_lookup = mk(440, 99, 349, 99);
			5'd2:    note_lookup = mk(392, 197, 311, 197);
			5'd3:    note_lookup = mk(349, 197, 392, 197);
			5'd4:    note_lookup = mk(392, 85, 349, 85);
			5'd5:    note_lookup = mk(311, 170, 440, 170);
			5'd6:    note_lookup = mk(440, 85, 415, 85);
			5'd7:    note_lookup = mk(349, 170, 294, 170);
			5'd8:    note_lookup = mk(294, 242, 349, 242);
			5'd9:    note_lookup = mk(349, 242, 311, 242);
			5'd10:   note_lookup = mk(294, 484, 294, 484);
			5'd11:   note_lookup = mk(440, 114, 349, 114);
			5'd12:   note_lookup = mk(349, 114, 311, 114);
			5'd13:   note_lookup = mk(440, 114, 349, 114);
			5'd14:   note_lookup = mk(0, 114, 0, 114);
			5'd15:   note_lookup = mk(311, 227, 392, 227);
			5'd16:   note_lookup = mk(0, 114, 0, 114);
			5'd17:   note_lookup = mk(440, 114, 349, 114);
			5'd18:   note_lookup = mk(349, 87, 311, 87);
			5'd19:   note_lookup = mk(392, 87, 349, 87);
			5'd20:   note_lookup = mk(440, 175, 392, 175);
			5'd21:   note_lookup = mk(440, 89, 392, 89);
			5'd22:   note_lookup = mk(392, 89, 349, 89);
			5'd23:   note_lookup = mk(349, 179, 311, 179);
			5'd24:   note_lookup = mk(220, 100, 220, 100);
			default: note_lookup = '0;
		endcase
	endfunction

	// First ROM step of each melody; entry TABLE_MELODIES is the end of the last.
	function automatic logic [4:0] melody_base(input logic [3:0] m);
		unique case (m)
			4'd0:    melody_base = 5'd0;
			4'd1:    melody_base = 5'd4;
			4'd2:    melody_base = 5'd6;
			4'd3:    melody_base = 5'd8;
			4'd4:    melody_base = 5'd11;
			4'd5:    melody_base = 5'd18;
			4'd6:    melody_base = 5'd21;
			4'd7:    melody_base = 5'd24;
			default: melody_base = 5'd25;
		endcase
	endfunction

endpackage

[design/tvns_step.sv]
// Next-state and result logic for one item of the note sequencer.
// Depends on tvns_pkg.
module tvns_step
	import tvns_pkg::*;
#(
	parameter int NUM_MELODIES = 8
) (
	input  item_t   item,
	input  state_t  st,
	input  cfg_t    cfg,
	output state_t  nxt,
	output result_t res
);

	note_t       note;
	logic [8:0]  dur;
	logic [15:0] left_raw, right_raw, left_bias, right_bias;
	logic        sel_ok;
	logic [3:0]  sel_ext;

	assign note = note_lookup(st.ptr);
	assign dur  = (note.ld > note.rd) ? note.ld : note.rd;

	// 0x8000 + signed drive is the drive with its sign bit flipped
	assign left_raw  = {~item.left_trim[15], item.left_trim[14:0]};
	assign right_raw = {~item.right_trim[15], item.right_trim[14:0]};

	function automatic logic [15:0] clamp(input logic [15:0] v, input cfg_t c);
		if (v < c.min_duty)      clamp = c.min_duty;
		else if (v > c.max_duty) clamp = c.max_duty;
		else                     clamp = v;
	endfunction

	assign left_bias  = clamp(left_raw, cfg);
	assign right_bias = clamp(right_raw, cfg);

	assign sel_ext = {1'b0, item.melody_select};
	assign sel_ok  = ({2'b00, item.melody_select} < 5'(NUM_MELODIES)) &&
		(32'(item.melody_select) < 32'(TABLE_MELODIES));

	always_comb begin
		nxt = st;
		res = '0;
		unique case (item.command)
			CMD_START: begin
				res.audio_end = st.active;
				if (sel_ok) begin
					nxt.ptr = melody_base(sel_ext);
					nxt.lim = melody_base(sel_ext + 4'd1);
				end else begin
					nxt.ptr = '0;
					nxt.lim = '0;
				end
				nxt.end_time    = '0;
				nxt.active      = 1'b1;
				res.audio_begin = 1'b1;
			end
			CMD_STOP: begin
				if (st.active) begin
					res.audio_end = 1'b1;
					nxt.active    = 1'b0;
				end
			end
			CMD_TICK, CMD_BIASED: begin
				if (st.active && item.now_ms >= st.end_time) begin
					if (st.ptr >= st.lim) begin
						res.audio_end = 1'b1;
						nxt.active    = 1'b0;
					end else begin
						nxt.ptr        = st.ptr + 5'd1;
						nxt.end_time   = item.now_ms + 32'(dur);
						res.note_valid = 1'b1;
						res.left_freq  = note.lf;
						res.right_freq = note.rf;
						if (item.command == CMD_BIASED) begin
							res.left_duty  = left_bias;
							res.right_duty = right_bias;
						end else begin
							res.left_duty  = cfg.plain_duty;
							res.right_duty = cfg.plain_duty;
						end
					end
				end
			end
			default: ;
		endcase
		res.playing = nxt.active;
	end

endmodule

[design/two_voice_note_sequencer.sv]
// Two-voice note sequencer: top level with stream ports and config registers.
// Depends on tvns_pkg, tvns_step and two_voice_note_sequencer_assert.svh.
//
// Plays one of eight built-in melodies as pairs of left/right frequencies.
// Each input beat carries a command in s_tuser: tick, biased tick, start
// melody or stop. Every input beat produces exactly one output beat. A tick
// emits the next note pair (m_tuser = 1) once now_ms reaches the end time of
// the previous note; the new end time is now_ms plus the longer of the two
// durations, wrapping at 2^32. A plain tick drives plain_duty on both voices;
// a biased tick drives 0.5 + drive/2 in Q0.16, clamped to [min_duty,
// max_duty] (lower limit tested first). Pipeline: one input register stage
// and one output register; an accepted beat waits in the input stage and
// its result is loaded into the output register once that is free or
// draining; one beat is taken every cycle while the output side keeps up.
// The ROM read, the time compare and the 32-bit end-time add all sit in the
// single stage between those registers. The output register decouples the
// two sides; input is held only when both the input stage and the output
// register are full and m_tready is low. Config writes (cfg_wen/cfg_addr/
// cfg_wdata) take effect at once and should only be done while idle.
module two_voice_note_sequencer
	import tvns_pkg::*;
#(
	parameter int NUM_MELODIES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// input beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // now_ms[31:0], melody_select[34:32],
	                              // left_trim[50:35], right_trim[66:51], zero fill
	input  logic [1:0]  s_tuser,  // command[1:0]
	// result beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // playing[0], left_freq[12:1], right_freq[24:13],
	                              // left_duty[40:25], right_duty[56:41],
	                              // audio_begin[57], audio_end[58], zero fill
	output logic        m_tuser,  // note_valid
	// configuration writes
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);

	`include "two_voice_note_sequencer_assert.svh"

	logic    valid_s1;
	item_t   item_s1;
	state_t  state_q, state_nxt;
	cfg_t    cfg_q;
	result_t res_nxt, res_q;
	logic    out_valid_q;
	logic    adv;
	logic    take;
	item_t   item_in;

	// Unpack the input beat.
	assign item_in = '{
		command:       s_tuser,
		now_ms:        s_tdata[31:0],
		melody_select: s_tdata[34:32],
		left_trim:     s_tdata[50:35],
		right_trim:    s_tdata[66:51]
	};

	// Process the held item whenever the output register is free or draining.
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_in;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_duty   <= MIN_DUTY_RST;
			cfg_q.max_duty   <= MAX_DUTY_RST;
			cfg_q.plain_duty <= PLAIN_DUTY_RST;
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				REG_MIN_DUTY:   cfg_q.min_duty   <= cfg_wdata;
				REG_MAX_DUTY:   cfg_q.max_duty   <= cfg_wdata;
				REG_PLAIN_DUTY: cfg_q.plain_duty <= cfg_wdata;
				default: ;
			endcase
		end
	end

	tvns_step #(
		.NUM_MELODIES(NUM_MELODIES)
	) u_step (
		.item (item_s1),
		.st   (state_q),
		.cfg  (cfg_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Player state advances together with the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.note_valid;
	assign m_tdata  = {5'd0, res_q.audio_end, res_q.audio_begin, res_q.right_duty,
		res_q.left_duty, res_q.right_freq, res_q.left_freq, res_q.playing};

	// A note is only ever emitted while the melody keeps playing.
	`TVNS_ASSERT_NOW(a_note_playing, out_valid_q && res_q.note_valid, res_q.playing)
	// A start always leaves the player running.
	`TVNS_ASSERT_NOW(a_begin_playing, out_valid_q && res_q.audio_begin, res_q.playing)
	// The step pointer never runs past the end of its melody.
	`TVNS_ASSERT_NOW(a_ptr_bound, 1'b1, state_q.ptr <= state_q.lim)
	// Every processed item lands in the output register.
	`TVNS_ASSERT_NEXT(a_adv_out, adv, out_valid_q)

endmodule

[tb/two_voice_note_sequencer_tb.sv]
// Self-checking testbench for the two-voice note sequencer stream block.
// Depends on tvns_pkg for the beat layouts and the command and register codes;
// keeps its own melody table and player state to predict every result beat.
module two_voice_note_sequencer_tb;
	import tvns_pkg::*;

	localparam int ROM_STEPS    = 25;
	localparam int PHASES       = 8;
	localparam int PHASE_BEATS  = 200;
	localparam int LONG_HOLD    = 80;
	localparam int SETTLE       = 4;

	// One melody step: left frequency and duration, right frequency and duration.
	typedef struct packed {
		logic [11:0] lf;
		logic [8:0]  ld;
		logic [11:0] rf;
		logic [8:0]  rd;
	} tone_step_t;

	typedef struct packed {
		item_t   stim;
		logic    typed;
		result_t want;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        m_tuser;
	logic        cfg_wen;
	logic [1:0]  cfg_addr;
	logic [15:0] cfg_wdata;

	// Melody table and the first step of each melody; the last entry closes melody 7.
	tone_step_t tone_rom [ROM_STEPS] = '{
		'{12'd349, 9'd99, 12'd311, 9'd99}, '{12'd440, 9'd99, 12'd349, 9'd99},
		'{12'd392, 9'd197, 12'd311, 9'd197}, '{12'd349, 9'd197, 12'd392, 9'd197},
		'{12'd392, 9'd85, 12'd349, 9'd85}, '{12'd311, 9'd170, 12'd440, 9'd170},
		'{12'd440, 9'd85, 12'd415, 9'd85}, '{12'd349, 9'd170, 12'd294, 9'd170},
		'{12'd294, 9'd242, 12'd349, 9'd242}, '{12'd349, 9'd242, 12'd311, 9'd242},
		'{12'd294, 9'd484, 12'd294, 9'd484},
		'{12'd440, 9'd114, 12'd349, 9'd114}, '{12'd349, 9'd114, 12'd311, 9'd114},
		'{12'd440, 9'd114, 12'd349, 9'd114}, '{12'd0, 9'd114, 12'd0, 9'd114},
		'{12'd311, 9'd227, 12'd392, 9'd227}, '{12'd0, 9'd114, 12'd0, 9'd114},
		'{12'd440, 9'd114, 12'd349, 9'd114},
		'{12'd349, 9'd87, 12'd311, 9'd87}, '{12'd392, 9'd87, 12'd349, 9'd87},
		'{12'd440, 9'd175, 12'd392, 9'd175},
		'{12'd440, 9'd89, 12'd392, 9'd89}, '{12'd392, 9'd89, 12'd349, 9'd89},
		'{12'd349, 9'd179, 12'd311, 9'd179},
		'{12'd220, 9'd100, 12'd220, 9'd100}
	};
	logic [4:0] tone_first [9] = '{5'd0, 5'd4, 5'd6, 5'd8, 5'd11, 5'd18, 5'd21, 5'd24, 5'd25};

	// Directed rows: typed results only where they follow at a glance.
	directed_row_t directed_rows [25] = '{
		// tick and biased tick while idle, stop while idle: nothing but playing 0
		'{'{CMD_TICK, 32'h0000_0000, 3'd0, 16'h0000, 16'h0000}, 1'b1,
			'{1'b0, 1'b0, 12'd0, 12'd0, 16'd0, 16'd0, 1'b0, 1'b0}},
		'{'{CMD_BIASED, 32'hFFFF_FFFF, 3'd7, 16'h8000, 16'h7FFF}, 1'b1,
			'{1'b0, 1'b0, 12'd0, 12'd0, 16'd0, 16'd0, 1'b0, 1'b0}},
		'{'{CMD_STOP, 32'hFFFF_FFFF, 3'd7, 16'hFFFF, 16'hFFFF}, 1'b1,
			'{1'b0, 1'b0, 12'd0, 12'd0, 16'd0, 16'd0, 1'b0, 1'b0}},
		// backup pip: one note, both drives at their extremes hit the clamps
		'{'{CMD_START, 32'h0000_0000, 3'd7, 16'h0000, 16'h0000}, 1'b1,
			'{1'b1, 1'b0, 12'd0, 12'd0, 16'd0, 16'd0, 1'b1, 1'b0}},
		'{'{CMD_BIASED, 32'h0000_0000, 3'd0, 16'h8000, 16'h7FFF}, 1'b1,
			'{1'b1, 1'b1, 12'd220, 12'd220, 16'd3277, 16'd62259, 1'b0, 1'b0}},
		'{'{CMD_TICK, 32'd99, 3'd0, 16'h0000, 16'h0000}, 1'b1,
			'{1'b1, 1'b0, 12'd0, 12'd0, 16'd0, 16'd0, 1'b0, 1'b0}},
		'{'{CMD_TICK, 32'd100, 3'd0, 16'h0000, 16'h0000}, 1'b1,
			'{1'b0, 1'b0, 12'd0, 12'd0, 16'd0, 16'd0, 1'b0, 1'b1}},
		// startup melody across the 32-bit time wrap
		'{'{CMD_START, 32'h0000_0000, 3'd0, 16'h0000, 16'h0000}, 1'b1,
			'{1'b1, 1'b0, 12'd0, 12'd0, 16'd0, 16'd0, 1'b1, 1'b0}},
		'{'{CMD_TICK, 32'hFFFF_FFF0, 3'd0, 16'h0000, 16'h0000}, 1'b1,
			'{1'b1, 1'b1, 12'd349, 12'd311, 16'd32768, 16'd32768, 1'b0, 1'b0}},
		'{'{CMD_TICK, 32'h0000_0052, 3'd0, 16'h0000, 16'h0000}, 1'b1,
			'{1'b1, 1'b0, 12'd0, 12'd0, 16'd0, 16'd0, 1'b0, 1'b0}},
		'{'{CMD_TICK, 32'h0000_0053, 3'd0, 16'h0000, 16'h0000}, 1'b0, '0},
		// start while playing: end and begin in the same beat
		'{'{CMD_START, 32'h0000_0000, 3'd4, 16'h0000, 16'h0000}, 1'b1,
			'{1'b1, 1'b0, 12'd0, 12'd0, 16'd0, 16'd0, 1'b1, 1'b1}},
		'{'{CMD_BIASED, 32'd1000, 3'd0, 16'h0000, 16'h0000}, 1'b0, '0},
		'{'{CMD_BIASED, 32'd1113, 3'd0, 16'h0000, 16'h0000}, 1'b0, '0},
		'{'{CMD_BIASED, 32'd1114, 3'd0, 16'hFFFF, 16'h0001}, 1'b0, '0},
		'{'{CMD_TICK, 32'd1300, 3'd0, 16'h0000, 16'h0000}, 1'b0, '0},
		'{'{CMD_BIASED, 32'd1500, 3'd0, 16'h5555, 16'hAAAA}, 1'b0, '0},
		'{'{CMD_STOP, 32'd1500, 3'd0, 16'h0000, 16'h0000}, 1'b1,
			'{1'b0, 1'b0, 12'd0, 12'd0, 16'd0, 16'd0, 1'b0, 1'b1}},
		// remaining melodies, each started; melodies 1 and 6 are also given one tick
		'{'{CMD_START, 32'd0, 3'd1, 16'h0000, 16'h0000}, 1'b0, '0},
		'{'{CMD_BIASED, 32'd5, 3'd0, 16'h7FFF, 16'h8000}, 1'b0, '0},
		'{'{CMD_START, 32'd0, 3'd2, 16'h0000, 16'h0000}, 1'b0, '0},
		'{'{CMD_START, 32'd0, 3'd3, 16'h0000, 16'h0000}, 1'b0, '0},
		'{'{CMD_START, 32'd0, 3'd5, 16'h0000, 16'h0000}, 1'b0, '0},
		'{'{CMD_START, 32'd0, 3'd6, 16'h0000, 16'h0000}, 1'b0, '0},
		'{'{CMD_TICK, 32'd7, 3'd0, 16'h0000, 16'h0000}, 1'b0, '0}
	};

	// Player copy and duty settings as the block should hold them.
	logic        seq_active;
	logic [4:0]  step_idx;
	logic [4:0]  step_end;
	logic [31:0] note_deadline;
	logic [15:0] duty_floor, duty_ceiling, duty_plain;

	result_t     pending_results [$];
	logic [31:0] play_clock;
	int          beats_sent;
	int          notes_heard;
	int          melody_ends;
	int          mismatches;
	bit          src_gaps;
	bit          sink_stalls;
	bit          hold_output_req;

	two_voice_note_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// 0.5 + drive/2 in Q0.16, lower limit tested before the upper one.
	function automatic logic [15:0] clamp_drive(input logic signed [15:0] drive);
		int level;
		level = 32768 + int'(drive);
		if (level < int'(duty_floor)) return duty_floor;
		if (level > int'(duty_ceiling)) return duty_ceiling;
		return level[15:0];
	endfunction

	// Advance the player copy by one input beat and return the result beat it causes.
	function automatic result_t predict_sequencer(input item_t it);
		result_t    r;
		tone_step_t step;
		logic [8:0] span;
		r = '0;
		if (it.command == CMD_START) begin
			r.audio_end = seq_active;
			// a 3-bit select is always a valid melody with eight in the table
			step_idx      = tone_first[it.melody_select];
			step_end      = tone_first[int'(it.melody_select) + 1];
			note_deadline = '0;
			seq_active    = 1'b1;
			r.audio_begin = 1'b1;
		end else if (it.command == CMD_STOP) begin
			r.audio_end = seq_active;
			seq_active  = 1'b0;
		end else if (seq_active && it.now_ms >= note_deadline) begin
			if (step_idx >= step_end) begin
				r.audio_end = 1'b1;
				seq_active  = 1'b0;
			end else begin
				step = (step_idx < ROM_STEPS) ? tone_rom[step_idx] : '0;
				step_idx = step_idx + 5'd1;
				r.left_freq  = step.lf;
				r.right_freq = step.rf;
				if (it.command == CMD_BIASED) begin
					r.left_duty  = clamp_drive(it.left_trim);
					r.right_duty = clamp_drive(it.right_trim);
				end else begin
					r.left_duty  = duty_plain;
					r.right_duty = duty_plain;
				end
				span = (step.ld > step.rd) ? step.ld : step.rd;
				note_deadline = it.now_ms + 32'(span);
				r.note_valid  = 1'b1;
			end
		end
		r.playing = seq_active;
		return r;
	endfunction

	function automatic logic signed [15:0] random_drive();
		case ($urandom_range(0, 5))
			0:       return 16'sh8000;
			1:       return 16'sh7FFF;
			2:       return 16'sh0000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Offer one beat, with an optional idle burst first; returns at the accepting edge.
	task automatic send_beat(input item_t it, input logic typed, input result_t want);
		result_t predicted;
		if (src_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, it.right_trim, it.left_trim, it.melody_select, it.now_ms};
		s_tuser  <= it.command;
		// sample the handshake mid-cycle, where every signal has settled
		do @(negedge clk); while (!s_tready);
		predicted = predict_sequencer(it);
		pending_results.push_back(typed ? want : predicted);
		beats_sent++;
		@(posedge clk);
	endtask

	// Drop valid and hold until every result beat is back, then let the pipe settle.
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write all three duty registers, one per cycle; only called while idle.
	task automatic set_duty_limits(input logic [15:0] lo, input logic [15:0] hi,
			input logic [15:0] plain);
		cfg_wen   <= 1'b1;
		cfg_addr  <= REG_MIN_DUTY;
		cfg_wdata <= lo;
		@(posedge clk);
		cfg_addr  <= REG_MAX_DUTY;
		cfg_wdata <= hi;
		@(posedge clk);
		cfg_addr  <= REG_PLAIN_DUTY;
		cfg_wdata <= plain;
		@(posedge clk);
		cfg_wen      <= 1'b0;
		duty_floor   = lo;
		duty_ceiling = hi;
		duty_plain   = plain;
	endtask

	// Mostly whole melodies with ticks aimed around each note end; the rest is noise.
	task automatic random_phase(input int beats);
		item_t it;
		int    stop_at;
		int    run_len;
		stop_at = beats_sent + beats;
		while (beats_sent < stop_at) begin
			it.now_ms        = $urandom;
			it.melody_select = 3'($urandom_range(0, 7));
			it.left_trim     = random_drive();
			it.right_trim    = random_drive();
			if ($urandom_range(0, 99) < 75) begin
				case ($urandom_range(0, 3))
					0:       play_clock = $urandom;
					1:       play_clock = 32'hFFFF_FFFF - $urandom_range(0, 700);
					default: ;
				endcase
				it.command = CMD_START;
				send_beat(it, 1'b0, '0);
				run_len = $urandom_range(1, 14);
				repeat (run_len) begin
					it.command = $urandom_range(0, 1) ? CMD_BIASED : CMD_TICK;
					case ($urandom_range(0, 9))
						0, 1:    play_clock = note_deadline - $urandom_range(1, 60);
						2:       play_clock = play_clock + $urandom_range(0, 400);
						default: play_clock = note_deadline + $urandom_range(0, 15);
					endcase
					it.now_ms        = play_clock;
					it.melody_select = 3'($urandom_range(0, 7));
					it.left_trim     = random_drive();
					it.right_trim    = random_drive();
					send_beat(it, 1'b0, '0);
				end
				if ($urandom_range(0, 3) == 0) begin
					it.command = CMD_STOP;
					send_beat(it, 1'b0, '0);
				end
			end else begin
				it.command = 2'($urandom_range(0, 3));
				send_beat(it, 1'b0, '0);
			end
		end
	endtask

	// Output side: ready with random stall bursts, or one long hold-off on request.
	initial begin
		m_tready <= 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			@(posedge clk);
			if (hold_output_req) begin
				hold_output_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				m_tready <= 1'b1;
			end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compare each accepted result beat with the oldest prediction.
	initial begin
		result_t want;
		forever begin
			@(negedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("result beat with nothing expected: tdata %h tuser %b",
						m_tdata, m_tuser);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("playing", want.playing, m_tdata[0]);
					check_field("note_valid", want.note_valid, m_tuser);
					check_field("left_freq", want.left_freq, m_tdata[12:1]);
					check_field("right_freq", want.right_freq, m_tdata[24:13]);
					check_field("left_duty", want.left_duty, m_tdata[40:25]);
					check_field("right_duty", want.right_duty, m_tdata[56:41]);
					check_field("audio_begin", want.audio_begin, m_tdata[57]);
					check_field("audio_end", want.audio_end, m_tdata[58]);
					notes_heard += m_tuser;
					melody_ends += m_tdata[58];
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("two_voice_note_sequencer regression: fail");
		$finish;
	end

	initial begin
		logic [15:0] lo_set    [PHASES];
		logic [15:0] hi_set    [PHASES];
		logic [15:0] plain_set [PHASES];
		lo_set        = '{16'd3277, 16'd0, 16'd65535, 16'd40000,
			16'd32768, 16'd0, 16'd16384, 16'd0};
		hi_set        = '{16'd62259, 16'd65535, 16'd0, 16'd20000,
			16'd32768, 16'd0, 16'd49152, 16'd0};
		plain_set     = '{16'd32768, 16'd0, 16'd65535, 16'd1,
			16'd65535, 16'd0, 16'd32767, 16'd0};
		arst_n        <= 1'b0;
		s_tvalid      <= 1'b0;
		s_tdata       <= '0;
		s_tuser       <= CMD_TICK;
		cfg_wen       <= 1'b0;
		cfg_addr      <= REG_MIN_DUTY;
		cfg_wdata     <= '0;
		seq_active    = 1'b0;
		step_idx      = '0;
		step_end      = '0;
		note_deadline = '0;
		duty_floor    = MIN_DUTY_RST;
		duty_ceiling  = MAX_DUTY_RST;
		duty_plain    = PLAIN_DUTY_RST;
		play_clock    = '0;
		beats_sent    = 0;
		notes_heard   = 0;
		melody_ends   = 0;
		mismatches    = 0;
		src_gaps      = 1'b1;
		sink_stalls   = 1'b1;
		hold_output_req = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows run on the reset duty settings.
		foreach (directed_rows[i])
			send_beat(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

		// Random phases, each on a fresh duty setting written while the block is idle.
		for (int p = 0; p < PHASES; p++) begin
			wait_for_results();
			if (p == 5 || p == 7)
				set_duty_limits(16'($urandom), 16'($urandom), 16'($urandom));
			else
				set_duty_limits(lo_set[p], hi_set[p], plain_set[p]);
			src_gaps    = (p != 6) && (p != PHASES - 1);
			sink_stalls = (p != 4) && (p != PHASES - 1);
			// fill the block against a stalled output early in this phase
			if (p == 2) hold_output_req = 1'b1;
			random_phase(PHASE_BEATS);
		end
		wait_for_results();

		if (pending_results.size() != 0) begin
			$error("%0d result beats never arrived", pending_results.size());
			mismatches++;
		end
		$display("covered %0d input beats: %0d note pairs, %0d melody ends, %0d duty settings",
			beats_sent, notes_heard, melody_ends, PHASES + 1);
		$display("included time wrap, crossed and extreme clamps, a long output hold-off");
		if (mismatches == 0) begin
			$display("two_voice_note_sequencer regression: pass");
		end else begin
			$display("two_voice_note_sequencer regression: fail");
		end
		$finish;
	end

endmodule
